// ===== design/dpbt_pkg.sv =====
// Shared types, constants and a helper function of the dirty page bitmap tracker.
// No dependencies. All other files but dpbt_ram use this package through scoped names.
`default_nettype none
package dpbt_pkg;

    // Bitmap geometry
    localparam longint unsigned PAGE_COUNT  = 64'd65536;
    localparam int              WORD_BITS   = 64;
    localparam int              PAGE_W      = 38;
    localparam longint unsigned NUM_WORDS   =
        (PAGE_COUNT + longint'(WORD_BITS) - 64'd1) / longint'(WORD_BITS);
    localparam int              BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int              WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Page limit one bit wider than a page number so that it can hold PAGE_COUNT itself
    localparam logic [PAGE_W:0]   PAGE_LIMIT = (PAGE_W + 1)'(PAGE_COUNT);
    localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(PAGE_COUNT - 64'd1);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 64'd1);
    localparam logic [WORD_BITS-1:0]  WORD_ONES = '1;
    localparam logic [BIT_IDX_W-1:0]  TOP_BIT   = BIT_IDX_W'(WORD_BITS - 1);

    // Request codes on the input port
    localparam logic [1:0] REQ_MARK  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_FIND  = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified operation
    typedef enum logic [2:0] {
        OP_MARK  = 3'd0,  // set one bit
        OP_QUERY = 3'd1,  // read one bit
        OP_FIND  = 3'd2,  // scan words for the first set bit
        OP_BAD   = 3'd3,  // mark beyond the page count
        OP_ZERO  = 3'd4   // result with all fields zero
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [WORD_IDX_W-1:0] word;
        logic [BIT_IDX_W-1:0]  off;
        logic [WORD_IDX_W-1:0] last_word;
        logic [BIT_IDX_W-1:0]  last_bit;
    } t_cmd;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Back end control toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // Position of the lowest set bit; zero when none is set
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

// ===== design/dpbt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module dpbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register read data; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/dpbt_front.sv =====
// Front end: accepts requests, range-checks and classifies them into commands,
// and holds them in a short queue for the back end. Depends on dpbt_pkg.
`default_nettype none
module dpbt_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [dpbt_pkg::PAGE_W-1:0]    i_page,
    input  wire logic [dpbt_pkg::PAGE_W-1:0]    i_end_page,
    input  wire dpbt_pkg::t_back_ctl            i_ctl,
    output dpbt_pkg::t_q_head                   o_head
);

    dpbt_pkg::t_cmd                          r_queue [dpbt_pkg::QUEUE_DEPTH];
    logic [dpbt_pkg::QUEUE_PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [dpbt_pkg::QUEUE_PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [dpbt_pkg::QUEUE_CNT_W-1:0]        r_count, n_count;

    logic                                    page_ok;
    logic                                    end_ok;
    logic [dpbt_pkg::PAGE_W-1:0]             last_page;
    dpbt_pkg::t_cmd                          cmd;
    logic                                    push;
    logic                                    full;

    // Clip the range end and check the page against the page count
    always_comb begin
        page_ok   = {1'b0, i_page} < dpbt_pkg::PAGE_LIMIT;
        end_ok    = {1'b0, i_end_page} < dpbt_pkg::PAGE_LIMIT;
        last_page = end_ok ? i_end_page : dpbt_pkg::LAST_PAGE;
    end

    // Classify the request
    always_comb begin
        cmd.word      = i_page[dpbt_pkg::BIT_IDX_W +: dpbt_pkg::WORD_IDX_W];
        cmd.off       = i_page[dpbt_pkg::BIT_IDX_W-1:0];
        cmd.last_word = last_page[dpbt_pkg::BIT_IDX_W +: dpbt_pkg::WORD_IDX_W];
        cmd.last_bit  = last_page[dpbt_pkg::BIT_IDX_W-1:0];
        case (i_req_type)
            dpbt_pkg::REQ_MARK:  cmd.op = page_ok ? dpbt_pkg::OP_MARK  : dpbt_pkg::OP_BAD;
            dpbt_pkg::REQ_QUERY: cmd.op = page_ok ? dpbt_pkg::OP_QUERY : dpbt_pkg::OP_ZERO;
            dpbt_pkg::REQ_FIND:  cmd.op = (i_page <= last_page) ? dpbt_pkg::OP_FIND
                                                                 : dpbt_pkg::OP_ZERO;
            default:             cmd.op = dpbt_pkg::OP_ZERO;
        endcase
    end

    // Stall when the queue is full or the bitmap is still being cleared
    assign full       = r_count == dpbt_pkg::QUEUE_CNT_W'(dpbt_pkg::QUEUE_DEPTH);
    assign o_in_stall = full || i_ctl.clearing;
    assign push       = i_in_valid && !o_in_stall;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = push      ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_ctl.pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

    // Present the oldest request
    assign o_head.valid = r_count != '0;
    assign o_head.cmd   = r_queue[r_rd_ptr];

endmodule
`default_nettype wire

// ===== design/dpbt_back.sv =====
// Back end: clears the bitmap after reset, executes mark, query and find
// commands against the bitmap RAM, and holds the result register.
// Depends on dpbt_pkg and dpbt_ram.
`default_nettype none
module dpbt_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dpbt_pkg::t_q_head              i_head,
    output dpbt_pkg::t_back_ctl                 o_ctl,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_status,
    output logic                                o_dirty,
    output logic [dpbt_pkg::PAGE_W-1:0]         o_found_page
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state                                  r_state, n_state;
    logic [dpbt_pkg::WORD_IDX_W-1:0]         r_clr_addr, n_clr_addr;
    dpbt_pkg::t_op                           r_op, n_op;
    logic [dpbt_pkg::WORD_IDX_W-1:0]         r_word, n_word;
    logic [dpbt_pkg::BIT_IDX_W-1:0]          r_off, n_off;
    logic [dpbt_pkg::WORD_IDX_W-1:0]         r_last_word, n_last_word;
    logic [dpbt_pkg::BIT_IDX_W-1:0]          r_last_bit, n_last_bit;

    logic                                    r_out_valid, n_out_valid;
    logic                                    r_status, n_status;
    logic                                    r_dirty, n_dirty;
    logic [dpbt_pkg::PAGE_W-1:0]             r_found, n_found;

    logic                                    ram_we;
    logic [dpbt_pkg::WORD_IDX_W-1:0]         ram_waddr;
    logic [dpbt_pkg::WORD_BITS-1:0]          ram_wdata;
    logic                                    ram_re;
    logic [dpbt_pkg::WORD_IDX_W-1:0]         ram_raddr;
    logic [dpbt_pkg::WORD_BITS-1:0]          ram_rdata;

    logic                                    out_free;
    logic                                    on_last;
    logic [dpbt_pkg::WORD_BITS-1:0]          hi_mask;
    logic [dpbt_pkg::WORD_BITS-1:0]          hits;
    logic [dpbt_pkg::BIT_IDX_W-1:0]          hit_pos;

    dpbt_ram #(
        .WIDTH (dpbt_pkg::WORD_BITS),
        .DEPTH (int'(dpbt_pkg::NUM_WORDS))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register is free when empty or when its result is taken
    assign out_free = !r_out_valid || !i_out_stall;

    // Mask the fetched word to the live part of the range
    always_comb begin
        on_last = r_word == r_last_word;
        hi_mask = on_last ? (dpbt_pkg::WORD_ONES >> (dpbt_pkg::TOP_BIT - r_last_bit))
                          : dpbt_pkg::WORD_ONES;
        hits    = ram_rdata & (dpbt_pkg::WORD_ONES << r_off) & hi_mask;
        hit_pos = dpbt_pkg::lowest_set(hits);
    end

    // Sequence clear, fetch and evaluate
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_op        = r_op;
        n_word      = r_word;
        n_off       = r_off;
        n_last_word = r_last_word;
        n_last_bit  = r_last_bit;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_dirty     = r_dirty;
        n_found     = r_found;
        ram_we      = 1'b0;
        ram_waddr   = r_word;
        ram_wdata   = ram_rdata | (dpbt_pkg::WORD_BITS'(1) << r_off);
        ram_re      = 1'b0;
        ram_raddr   = i_head.cmd.word;
        o_ctl.pop   = 1'b0;
        o_ctl.clearing = r_state == S_CLEAR;

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == dpbt_pkg::LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_ctl.pop   = 1'b1;
                    ram_re      = 1'b1;
                    n_op        = i_head.cmd.op;
                    n_word      = i_head.cmd.word;
                    n_off       = i_head.cmd.off;
                    n_last_word = i_head.cmd.last_word;
                    n_last_bit  = i_head.cmd.last_bit;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_op == dpbt_pkg::OP_FIND && hits == '0 && !on_last) begin
                    // Move to the next word of the range
                    ram_re    = 1'b1;
                    ram_raddr = r_word + 1'b1;
                    n_word    = r_word + 1'b1;
                    n_off     = '0;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b0;
                    n_dirty     = 1'b0;
                    n_found     = '0;
                    n_state     = S_IDLE;
                    case (r_op)
                        dpbt_pkg::OP_MARK:  ram_we   = 1'b1;
                        dpbt_pkg::OP_QUERY: n_dirty  = ram_rdata[r_off];
                        dpbt_pkg::OP_FIND: begin
                            if (hits != '0) begin
                                n_dirty = 1'b1;
                                n_found = dpbt_pkg::PAGE_W'({r_word, hit_pos});
                            end
                        end
                        dpbt_pkg::OP_BAD:   n_status = 1'b1;
                        default:            n_status = 1'b0;
                    endcase
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold command and result payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_word      <= n_word;
        r_off       <= n_off;
        r_last_word <= n_last_word;
        r_last_bit  <= n_last_bit;
        r_status    <= n_status;
        r_dirty     <= n_dirty;
        r_found     <= n_found;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_dirty      = r_dirty;
    assign o_found_page = r_found;

    // A command leaves the queue only when the sequencer is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.pop |-> r_state == S_IDLE)
        else $error("queue popped outside idle");

    // The bitmap is written only by the clear pass or by a mark
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || (r_state == S_EVAL && r_op == dpbt_pkg::OP_MARK)))
        else $error("unexpected bitmap write");

    // A new result appears only after an evaluate cycle
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && r_state != S_EVAL) |=> !r_out_valid)
        else $error("result loaded outside evaluate");

    // A scan never passes the last word of its range
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_op == dpbt_pkg::OP_FIND) |-> r_word <= r_last_word)
        else $error("scan beyond range end");

endmodule
`default_nettype wire

// ===== design/dirty_page_bitmap_tracker_core.sv =====
// Dirty page bitmap tracker: keeps one dirty bit per page in a RAM of 64-bit words
// (1024 words for 65536 pages) and answers mark, query and find-next requests, one
// result per request, in request order. After reset the block clears the bitmap,
// one word per cycle, and holds o_in_stall high meanwhile. A mark or a query then
// goes through a RAM read, then evaluate and write, in the back end. A find-next
// reads the start page's word, then fetches one word per cycle through the single
// RAM read port up to the word holding the first dirty page or the clipped range
// end. A two-entry request queue keeps accepting requests, until it is full, while
// the back end works or its result waits to be taken. Depends on dpbt_pkg,
// dpbt_front, dpbt_back.
`default_nettype none
module dirty_page_bitmap_tracker_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [dpbt_pkg::PAGE_W-1:0]    i_page,
    input  wire logic [dpbt_pkg::PAGE_W-1:0]    i_end_page,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_status,
    output logic                                o_dirty,
    output logic [dpbt_pkg::PAGE_W-1:0]         o_found_page
);

    dpbt_pkg::t_q_head   head;
    dpbt_pkg::t_back_ctl ctl;

    dpbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_page     (i_page),
        .i_end_page (i_end_page),
        .i_ctl      (ctl),
        .o_head     (head)
    );

    dpbt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_ctl        (ctl),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_dirty      (o_dirty),
        .o_found_page (o_found_page)
    );

endmodule
`default_nettype wire

// ===== sim/dirty_page_bitmap_tracker_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dirty_page_bitmap_tracker_core: sends mark, query, find-next
// and unused-code requests, predicts every result from its own copy of the page bitmap.
// Depends on dpbt_pkg and the tracker RTL.
module dirty_page_bitmap_tracker_core_tb;

    localparam int              PW         = dpbt_pkg::PAGE_W;
    localparam int              WB         = dpbt_pkg::WORD_BITS;
    localparam int              MAP_WORDS  = int'(dpbt_pkg::NUM_WORDS);
    localparam longint unsigned NPAGES     = dpbt_pkg::PAGE_COUNT;
    localparam logic [1:0]      REQ_UNUSED = 2'd3;
    localparam logic [PW-1:0]   ALL_ONES   = '1;
    localparam int              IDLE_LIMIT = 20000;
    localparam int              RAND_REQS  = 2000;
    localparam int              DRAIN_PAD  = 20;

    typedef struct packed {
        logic          status;
        logic          dirty;
        logic [PW-1:0] found_page;
    } t_page_result;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    // Bitmap copy, expected results in request order, and error bookkeeping
    class dirty_map_scoreboard;
        bit [WB-1:0]  dirty_words [MAP_WORDS];
        t_page_result pending [$];
        int           n_errors;
        int           n_checked;
        int           n_by_kind [4];

        // Apply one accepted request to the bitmap copy and queue its result
        function t_page_result note_request(logic [1:0] kind, logic [PW-1:0] page,
                                            logic [PW-1:0] last);
            t_page_result    res;
            longint unsigned p;
            longint unsigned bound;
            longint unsigned w;
            logic [WB-1:0]   v;
            bit              scanning;
            res = '0;
            p   = page;
            n_by_kind[kind]++;
            case (kind)
                dpbt_pkg::REQ_MARK: begin
                    if (p >= NPAGES) begin
                        res.status = 1'b1;
                    end else begin
                        dirty_words[p / WB][p % WB] = 1'b1;
                    end
                end
                dpbt_pkg::REQ_QUERY: begin
                    if (p < NPAGES) begin
                        res.dirty = dirty_words[p / WB][p % WB];
                    end
                end
                dpbt_pkg::REQ_FIND: begin
                    // clip the range end to the last page, then walk word by word
                    bound = last;
                    bound = bound + 1;
                    if (bound > NPAGES) begin
                        bound = NPAGES;
                    end
                    scanning = (p < bound);
                    while (scanning) begin
                        w = p / WB;
                        v = dirty_words[w] >> (p % WB);
                        if (v != '0) begin
                            while (!v[0]) begin
                                v = v >> 1;
                                p++;
                            end
                            if (p < bound) begin
                                res.dirty      = 1'b1;
                                res.found_page = PW'(p);
                            end
                            scanning = 1'b0;
                        end else begin
                            p        = (w + 1) * WB;
                            scanning = (p < bound);
                        end
                    end
                end
                default: begin
                end
            endcase
            pending.push_back(res);
            return res;
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic status, logic dirty, logic [PW-1:0] found_page);
            t_page_result want;
            if (pending.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: status %0b dirty %0b found_page %0d",
                         $time, status, dirty, found_page);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (status !== want.status) begin
                n_errors++;
                $display("%0t: status mismatch: expected %0b, actual %0b",
                         $time, want.status, status);
            end
            if (dirty !== want.dirty) begin
                n_errors++;
                $display("%0t: dirty mismatch: expected %0b, actual %0b",
                         $time, want.dirty, dirty);
            end
            if (found_page !== want.found_page) begin
                n_errors++;
                $display("%0t: found_page mismatch: expected %0d, actual %0d",
                         $time, want.found_page, found_page);
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [1:0]    i_req_type  = '0;
    logic [PW-1:0] i_page      = '0;
    logic [PW-1:0] i_end_page  = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic          o_status;
    logic          o_dirty;
    logic [PW-1:0] o_found_page;

    dirty_map_scoreboard sb;
    int                  burst_left  = 8;
    int                  n_sent      = 0;
    int                  n_drains    = 0;
    int                  idle_cycles = 0;
    t_sink_mode          sink_mode   = SINK_OPEN;
    int                  sink_left   = 0;

    dirty_page_bitmap_tracker_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_page       (i_page),
        .i_end_page   (i_end_page),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_dirty      (o_dirty),
        .o_found_page (o_found_page)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Any page number across the whole 38-bit field
    function automatic logic [PW-1:0] any_page();
        return PW'({$urandom(), $urandom()});
    endfunction

    // Present one request, hold it until accepted, then idle between bursts
    task automatic send_req(input logic [1:0] kind, input logic [PW-1:0] page,
                            input logic [PW-1:0] last, output t_page_result res);
        int gap;
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_page     <= page;
        i_end_page <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        res = sb.note_request(kind, page, last);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off new requests until every expected result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        n_drains++;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Take results and vary the stall pattern in phases
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_dirty, o_found_page);
        end
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(50, 400);
        end else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_OPEN:   i_out_stall <= 1'b0;
            SINK_RANDOM: i_out_stall <= ($urandom_range(0, 1) == 1);
            default:     i_out_stall <= ((sink_left % 8) >= 5);
        endcase
    end

    // Stop the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_page_result  res;
        logic [PW-1:0] s;
        logic [PW-1:0] e;
        logic [PW-1:0] base;
        int            pick;
        int            n;
        int            steps;
        int            next_move;
        sb = new();

        // Hold reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, range clipping, word edges and the unused code
        send_req(dpbt_pkg::REQ_QUERY, '0, '0, res);
        send_req(dpbt_pkg::REQ_FIND, '0, ALL_ONES, res);
        send_req(dpbt_pkg::REQ_MARK, '0, '0, res);
        send_req(dpbt_pkg::REQ_MARK, dpbt_pkg::LAST_PAGE, '0, res);
        send_req(dpbt_pkg::REQ_MARK, PW'(NPAGES), '0, res);
        send_req(dpbt_pkg::REQ_MARK, ALL_ONES, ALL_ONES, res);
        send_req(dpbt_pkg::REQ_QUERY, '0, '0, res);
        send_req(dpbt_pkg::REQ_QUERY, dpbt_pkg::LAST_PAGE, '0, res);
        send_req(dpbt_pkg::REQ_QUERY, PW'(NPAGES), '0, res);
        send_req(dpbt_pkg::REQ_QUERY, ALL_ONES, '0, res);
        send_req(dpbt_pkg::REQ_FIND, '0, '0, res);
        send_req(dpbt_pkg::REQ_FIND, PW'(1), ALL_ONES, res);
        send_req(dpbt_pkg::REQ_FIND, PW'(1), dpbt_pkg::LAST_PAGE - 1'b1, res);
        send_req(dpbt_pkg::REQ_FIND, PW'(100), PW'(50), res);
        send_req(dpbt_pkg::REQ_FIND, ALL_ONES, ALL_ONES, res);
        send_req(dpbt_pkg::REQ_MARK, PW'(63), '0, res);
        send_req(dpbt_pkg::REQ_MARK, PW'(64), '0, res);
        send_req(dpbt_pkg::REQ_FIND, PW'(1), ALL_ONES, res);
        send_req(dpbt_pkg::REQ_FIND, PW'(64), PW'(64), res);
        send_req(dpbt_pkg::REQ_FIND, PW'(65), dpbt_pkg::LAST_PAGE, res);
        send_req(REQ_UNUSED, ALL_ONES, ALL_ONES, res);
        send_req(REQ_UNUSED, '0, '0, res);
        send_req(dpbt_pkg::REQ_QUERY, PW'(64), '0, res);
        wait_drained();

        // Random traffic clustered in a moving window of pages
        base      = '0;
        next_move = n_sent;
        while (n_sent < RAND_REQS) begin
            if (n_sent >= next_move) begin
                base      = PW'($urandom_range(0, int'(NPAGES) - 2048));
                next_move = n_sent + $urandom_range(100, 300);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_req(dpbt_pkg::REQ_MARK, PW'(base + $urandom_range(0, 2047)),
                             any_page(), res);
                end
            end else if (pick < 60) begin
                n = $urandom_range(0, 19);
                if (n < 14) begin
                    s = PW'(base + $urandom_range(0, 2047));
                end else if (n < 19) begin
                    s = PW'($urandom_range(0, int'(NPAGES) - 1));
                end else begin
                    s = any_page();
                end
                send_req(dpbt_pkg::REQ_QUERY, s, any_page(), res);
            end else if (pick < 85) begin
                // walk the dirty pages of a range, each step past the last hit
                s = PW'(base + $urandom_range(0, 2047));
                e = ($urandom_range(0, 9) == 0) ? any_page()
                                                : PW'(s + $urandom_range(0, 1500));
                steps = $urandom_range(1, 8);
                for (int k = 0; k < steps; k++) begin
                    send_req(dpbt_pkg::REQ_FIND, s, e, res);
                    if (!res.dirty) begin
                        k = steps;
                    end else begin
                        s = res.found_page + 1'b1;
                    end
                end
            end else if (pick < 97) begin
                send_req(2'($urandom_range(0, 3)), any_page(), any_page(), res);
            end else begin
                send_req(dpbt_pkg::REQ_FIND, PW'($urandom_range(0, int'(NPAGES) - 1)),
                         ALL_ONES, res);
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_drained();
            end
        end

        // Let the last results come back, then watch for strays
        wait_drained();
        repeat (DRAIN_PAD) @(posedge i_clk);

        $display("Sent %0d requests (%0d mark, %0d query, %0d find, %0d unused code),",
                 n_sent, sb.n_by_kind[0], sb.n_by_kind[1], sb.n_by_kind[2],
                 sb.n_by_kind[3]);
        $display("checked %0d results under bursty input gaps, phased output stalls %s",
                 sb.n_checked, $sformatf("and %0d drains.", n_drains));
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dpbt_pkg.sv
design/dpbt_ram.sv
design/dpbt_front.sv
design/dpbt_back.sv
design/dirty_page_bitmap_tracker_core.sv
sim/dirty_page_bitmap_tracker_core_tb.sv
